// ===== hdl/concentric_square_to_disk_map_top_macros.svh =====
// Assertion macros for the concentric square-to-disk map block.
// Included by the top level; depends on nothing else.
`ifndef CONCENTRIC_SQUARE_TO_DISK_MAP_TOP_MACROS_SVH
`define CONCENTRIC_SQUARE_TO_DISK_MAP_TOP_MACROS_SVH
`define CSDM_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define CSDM_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ===== hdl/csdm_pkg.sv =====
// Package for the concentric square-to-disk map: payload types, constants
// and the CORDIC arctangent table. Depends on nothing.
`default_nettype none
package csdm_pkg;
   localparam int SampleBitsDef = 16;
   localparam int TrigStepsDef  = 16;
   localparam int QuotBits      = 30;
   localparam logic [29:0] PiOver4Q30 = 30'd843314857;
   localparam logic [29:0] InvGainQ30 = 30'd652032874;

   typedef struct packed {
      logic [15:0] square_x;
      logic [15:0] square_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] disk_x;
      logic signed [15:0] disk_y;
   } rsp_type;

   typedef enum logic [3:0] {
      REG0 = 4'b0001, REG1 = 4'b0010, REG2 = 4'b0100, REG3 = 4'b1000
   } region_type;

   function automatic logic signed [33:0] atan_step(input int i);
      logic signed [33:0] v;
      v = '0;
      unique case (i)
         0: v = 34'sd843314857;
         1: v = 34'sd497837829;
         2: v = 34'sd263043837;
         3: v = 34'sd133525159;
         4: v = 34'sd67021687;
         5: v = 34'sd33543516;
         6: v = 34'sd16775851;
         7: v = 34'sd8388437;
         8: v = 34'sd4194283;
         9: v = 34'sd2097149;
         10: v = 34'sd1048576;
         default: v = (i <= 30) ? (34'sd1 <<< (30 - i)) : 34'sd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

// ===== hdl/csdm_front.sv =====
// Front stage: centres the sample, picks the region and the radius.
// Depends on csdm_pkg.
`default_nettype none
module csdm_front #(
   parameter int SAMPLE_BITS = csdm_pkg::SampleBitsDef
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire logic                   in_valid,
   input  wire csdm_pkg::req_type      in_req,
   output logic                        out_valid,
   output csdm_pkg::region_type        out_region,
   output logic [SAMPLE_BITS:0]        out_r,
   output logic [SAMPLE_BITS:0]        out_num,
   output logic                        out_neg,
   output logic                        out_zero
);
   localparam int W = SAMPLE_BITS + 2;
   logic signed [W-1:0] a, b, one_s, num, den;
   logic [SAMPLE_BITS-1:0] sx, sy;
   csdm_pkg::region_type region;
   logic valid_ff;
   csdm_pkg::region_type region_ff;
   logic [SAMPLE_BITS:0] r_ff, num_ff;
   logic neg_ff, zero_ff;

   always_comb begin
      sx = SAMPLE_BITS'(in_req.square_x);
      sy = SAMPLE_BITS'(in_req.square_y);
      one_s = W'(1) <<< SAMPLE_BITS;
      a = (W'(sx) <<< 1) - one_s;
      b = (W'(sy) <<< 1) - one_s;
      if (a > -b) begin
         if (a > b) begin region = csdm_pkg::REG0; num = b; den = a; end
         else begin region = csdm_pkg::REG1; num = a; den = b; end
      end else begin
         if (a < b) begin region = csdm_pkg::REG2; num = b; den = a; end
         else begin region = csdm_pkg::REG3; num = a; den = b; end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         region_ff <= region;
         r_ff <= (den[W-1] ? (SAMPLE_BITS+1)'(-den) : (SAMPLE_BITS+1)'(den));
         num_ff <= (num[W-1] ? (SAMPLE_BITS+1)'(-num) : (SAMPLE_BITS+1)'(num));
         neg_ff <= (num[W-1] != den[W-1]);
         zero_ff <= (den == '0);
      end
   end

   assign out_valid = valid_ff;
   assign out_region = region_ff;
   assign out_r = r_ff;
   assign out_num = num_ff;
   assign out_neg = neg_ff;
   assign out_zero = zero_ff;
endmodule
`default_nettype wire

// ===== hdl/csdm_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, Q30 magnitude
// ratio of two unsigned values. Depends on csdm_pkg.
`default_nettype none
module csdm_div #(
   parameter int SAMPLE_BITS = csdm_pkg::SampleBitsDef,
   parameter int TAG_BITS = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic                      in_valid,
   input  wire logic [SAMPLE_BITS:0]      in_num,
   input  wire logic [SAMPLE_BITS:0]      in_den,
   input  wire logic [TAG_BITS-1:0]       in_tag,
   output logic                           out_valid,
   output logic [csdm_pkg::QuotBits:0]    out_q,
   output logic [SAMPLE_BITS:0]           out_den,
   output logic [TAG_BITS-1:0]            out_tag
);
   localparam int N = csdm_pkg::QuotBits + 1;
   localparam int RW = SAMPLE_BITS + 2;
   logic                  v_ff   [N+1];
   logic [RW-1:0]         rem_ff [N+1];
   logic [N-1:0]          q_ff   [N+1];
   logic [SAMPLE_BITS:0]  d_ff   [N+1];
   logic [TAG_BITS-1:0]   t_ff   [N+1];

   // The numerator never exceeds the denominator, so the integer part of
   // the quotient is a single bit decided by the first stage; the later
   // stages bring down the zero bits of the Q30 fraction.
   assign v_ff[0] = in_valid;
   assign rem_ff[0] = RW'(in_num);
   assign q_ff[0] = '0;
   assign d_ff[0] = in_den;
   assign t_ff[0] = in_tag;

   for (genvar k = 0; k < N; k++) begin : g_st
      logic [RW-1:0] sh, df;
      logic ge;
      always_comb begin
         sh = (k == 0) ? rem_ff[k] : {rem_ff[k][RW-2:0], 1'b0};
         ge = sh >= RW'(d_ff[k]);
         df = sh - RW'(d_ff[k]);
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[k+1] <= 1'b0;
         else if (adv) v_ff[k+1] <= v_ff[k];
         if (adv) begin
            rem_ff[k+1] <= ge ? df : sh;
            q_ff[k+1] <= {q_ff[k][N-2:0], ge};
            d_ff[k+1] <= d_ff[k];
            t_ff[k+1] <= t_ff[k];
         end
      end
   end

   assign out_valid = v_ff[N];
   assign out_q = q_ff[N];
   assign out_den = d_ff[N];
   assign out_tag = t_ff[N];
endmodule
`default_nettype wire

// ===== hdl/csdm_cordic.sv =====
// Pipelined rotation CORDIC, one step per stage, Q30 angle and vector.
// Depends on csdm_pkg.
`default_nettype none
module csdm_cordic #(
   parameter int TRIG_STEPS = csdm_pkg::TrigStepsDef,
   parameter int TAG_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 adv,
   input  wire logic                 in_valid,
   input  wire logic signed [33:0]   in_x,
   input  wire logic signed [33:0]   in_z,
   input  wire logic [TAG_BITS-1:0]  in_tag,
   output logic                      out_valid,
   output logic signed [33:0]        out_x,
   output logic signed [33:0]        out_y,
   output logic [TAG_BITS-1:0]       out_tag
);
   logic                v_ff [TRIG_STEPS+1];
   logic signed [33:0]  x_ff [TRIG_STEPS+1];
   logic signed [33:0]  y_ff [TRIG_STEPS+1];
   logic signed [33:0]  z_ff [TRIG_STEPS+1];
   logic [TAG_BITS-1:0] t_ff [TRIG_STEPS+1];

   assign v_ff[0] = in_valid;
   assign x_ff[0] = in_x;
   assign y_ff[0] = '0;
   assign z_ff[0] = in_z;
   assign t_ff[0] = in_tag;

   for (genvar i = 0; i < TRIG_STEPS; i++) begin : g_st
      logic signed [33:0] dx, dy, at;
      always_comb begin
         dx = y_ff[i] >>> i;
         dy = x_ff[i] >>> i;
         at = csdm_pkg::atan_step(i);
      end
      always_ff @(posedge clock) begin
         if (reset) v_ff[i+1] <= 1'b0;
         else if (adv) v_ff[i+1] <= v_ff[i];
         if (adv) begin
            if (!z_ff[i][33]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + at;
            end
            t_ff[i+1] <= t_ff[i];
         end
      end
   end

   assign out_valid = v_ff[TRIG_STEPS];
   assign out_x = x_ff[TRIG_STEPS];
   assign out_y = y_ff[TRIG_STEPS];
   assign out_tag = t_ff[TRIG_STEPS];
endmodule
`default_nettype wire

// ===== hdl/concentric_square_to_disk_map_top.sv =====
// Concentric square-to-disk map.
// One request carries a unit-square sample (square_x, square_y); one
// response carries the disk point (disk_x, disk_y) in signed Q1.15.
// Both channels use valid and stall; a request or response moves at a
// rising edge with valid high and stall low.
// The block is a fixed pipeline: a front stage, a 31-stage restoring
// divider (one quotient bit per stage), one multiply stage for the angle
// and the initial radius, TRIG_STEPS CORDIC stages and an output stage.
// One request is taken every cycle while the pipeline is not stalled.
// The whole pipeline advances as one when the output register is empty or
// the response is taken, so a stall on the response channel freezes every
// stage and propagates to req_stall in the same cycle; nothing is lost.
// Synchronous reset clears all valid bits; payload registers keep data.
// Depends on csdm_pkg, csdm_front, csdm_div, csdm_cordic and the macro header.
`default_nettype none
`include "concentric_square_to_disk_map_top_macros.svh"
module concentric_square_to_disk_map_top #(
   parameter int SAMPLE_BITS = csdm_pkg::SampleBitsDef,
   parameter int TRIG_STEPS  = csdm_pkg::TrigStepsDef
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire csdm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output csdm_pkg::rsp_type      rsp_data
);
   localparam int TB = 6;
   typedef struct packed {
      logic [3:0] region;
      logic       neg;
      logic       zero;
   } tag_type;

   logic adv;
   assign adv = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   logic f_valid, f_neg, f_zero;
   csdm_pkg::region_type f_region;
   logic [SAMPLE_BITS:0] f_r, f_num;

   csdm_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(req_valid),
      .in_req(req_data), .out_valid(f_valid), .out_region(f_region),
      .out_r(f_r), .out_num(f_num), .out_neg(f_neg), .out_zero(f_zero));

   tag_type f_tag;
   assign f_tag = '{region: f_region, neg: f_neg, zero: f_zero};

   logic d_valid;
   logic [csdm_pkg::QuotBits:0] d_q;
   logic [SAMPLE_BITS:0] d_den;
   logic [TB-1:0] d_tag;

   csdm_div #(.SAMPLE_BITS(SAMPLE_BITS), .TAG_BITS(TB)) u_div (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(f_valid),
      .in_num(f_num), .in_den(f_r), .in_tag(f_tag), .out_valid(d_valid),
      .out_q(d_q), .out_den(d_den), .out_tag(d_tag));

   // Angle and initial vector.
   logic          m_valid_ff;
   logic [61:0]   m_z_ff;
   logic [SAMPLE_BITS+30:0] m_x_ff;
   tag_type       m_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) m_valid_ff <= 1'b0;
      else if (adv) m_valid_ff <= d_valid;
      if (adv) begin
         m_z_ff <= 62'(d_q) * 62'(csdm_pkg::PiOver4Q30);
         m_x_ff <= (SAMPLE_BITS+31)'(d_den) * (SAMPLE_BITS+31)'(csdm_pkg::InvGainQ30);
         m_tag_ff <= d_tag;
      end
   end

   logic c_valid;
   logic signed [33:0] c_x, c_y;
   logic [TB-1:0] c_tag;
   csdm_cordic #(.TRIG_STEPS(TRIG_STEPS), .TAG_BITS(TB)) u_cordic (
      .clock(clock), .reset(reset), .adv(adv), .in_valid(m_valid_ff),
      .in_x(34'(m_x_ff >> SAMPLE_BITS)), .in_z(34'(m_z_ff >> 30)),
      .in_tag(m_tag_ff), .out_valid(c_valid), .out_x(c_x), .out_y(c_y),
      .out_tag(c_tag));

   tag_type ct;
   logic signed [33:0] ys;
   logic signed [18:0] c, s, ox, oy;
   csdm_pkg::rsp_type rsp_in;
   always_comb begin
      ct = c_tag;
      ys = ct.neg ? -c_y : c_y;
      c = 19'(c_x >>> 15);
      s = 19'(ys >>> 15);
      unique case (csdm_pkg::region_type'(ct.region))
         csdm_pkg::REG0: begin ox = c;  oy = s;  end
         csdm_pkg::REG1: begin ox = s;  oy = c;  end
         csdm_pkg::REG2: begin ox = -c; oy = -s; end
         default:        begin ox = -s; oy = -c; end
      endcase
      rsp_in.disk_x = (ox > 19'sd32767) ? 16'sh7fff :
                      (ox < -19'sd32768) ? 16'sh8000 : 16'(ox);
      rsp_in.disk_y = (oy > 19'sd32767) ? 16'sh7fff :
                      (oy < -19'sd32768) ? 16'sh8000 : 16'(oy);
      if (ct.zero) rsp_in = '0;
   end

   logic rsp_valid_ff;
   csdm_pkg::rsp_type rsp_data_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= c_valid;
      if (adv) rsp_data_ff <= rsp_in;
   end
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   `CSDM_ASSERT_IMPLY(a_stall_link, clock, reset, rsp_valid && rsp_stall, req_stall)
   `CSDM_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `CSDM_ASSERT_IMPLY(a_zero_out, clock, reset, adv && c_valid && ct.zero, rsp_in == '0)
endmodule
`default_nettype wire
